/* hdl/mnpt_pkg.sv */
`timescale 1ns / 1ps

package mnpt_pkg;

    localparam int NOTE_COUNT   = 128;
    localparam int PITCH_BITS   = $clog2(NOTE_COUNT);
    localparam int VEL_BITS     = 7;
    localparam int STATUS_BITS  = 8;
    localparam int PORT_TICK_W  = 32;
    localparam int TICK_BITS_DEF = 32;

    localparam logic [STATUS_BITS-1:0] CMD_MASK     = 8'hf0;
    localparam logic [STATUS_BITS-1:0] CMD_NOTE_ON  = 8'h90;
    localparam logic [STATUS_BITS-1:0] CMD_NOTE_OFF = 8'h80;

    // finished note waiting between the table stage and the output stage
    typedef struct packed {
        logic                  hit;
        logic [PITCH_BITS-1:0] pitch;
        logic [VEL_BITS-1:0]   strength;
    } pair_ctrl_t;

endpackage

/* hdl/midi_note_pair_tracker_unit.sv */
`timescale 1ns / 1ps
// a matching note-off is registered in the table stage (hit_reg), then in the output stage (valid_reg)
// throughput: one item per cycle while in_stall is low; the start-tick memory takes one access per item
// stall reaches the input only when a finished note waits behind a held output
// reset (rst_n, asynchronous, active low) closes all notes, zeroes the last
// velocity and empties the pipeline; the start-tick memory is not cleared

module midi_note_pair_tracker_unit #(
    parameter int TICK_BITS = mnpt_pkg::TICK_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [mnpt_pkg::STATUS_BITS-1:0]   status_byte,
    input  logic [mnpt_pkg::PITCH_BITS-1:0]    note_number,
    input  logic [mnpt_pkg::VEL_BITS-1:0]      note_velocity,
    input  logic [mnpt_pkg::PORT_TICK_W-1:0]   event_tick,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [mnpt_pkg::PORT_TICK_W-1:0]   start_tick,
    output logic [mnpt_pkg::PITCH_BITS-1:0]    note_pitch,
    output logic [mnpt_pkg::PORT_TICK_W-1:0]   note_length,
    output logic [mnpt_pkg::VEL_BITS-1:0]      note_strength
);
    import mnpt_pkg::*;

    pair_ctrl_t              ctrl;
    logic [TICK_BITS-1:0]    tick;
    logic [TICK_BITS-1:0]    start_q;
    logic [TICK_BITS-1:0]    tick_q;
    logic                    advance;
    logic                    accept;

    assign tick     = TICK_BITS'(event_tick);
    assign in_stall = ctrl.hit && !advance;
    assign accept   = in_valid && !in_stall;

    mnpt_table #(
        .TICK_BITS (TICK_BITS)
    ) u_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .advance     (advance),
        .status_byte (status_byte),
        .pitch       (note_number),
        .velocity    (note_velocity),
        .tick        (tick),
        .ctrl        (ctrl),
        .start_q     (start_q),
        .tick_q      (tick_q)
    );

    mnpt_out #(
        .TICK_BITS (TICK_BITS)
    ) u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .start_q       (start_q),
        .tick_q        (tick_q),
        .out_stall     (out_stall),
        .advance       (advance),
        .out_valid     (out_valid),
        .start_tick    (start_tick),
        .note_pitch    (note_pitch),
        .note_length   (note_length),
        .note_strength (note_strength)
    );

endmodule

/* hdl/mnpt_table.sv */
`timescale 1ns / 1ps

module mnpt_table #(
    parameter int TICK_BITS = mnpt_pkg::TICK_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               accept,
    input  logic                               advance,
    input  logic [mnpt_pkg::STATUS_BITS-1:0]   status_byte,
    input  logic [mnpt_pkg::PITCH_BITS-1:0]    pitch,
    input  logic [mnpt_pkg::VEL_BITS-1:0]      velocity,
    input  logic [TICK_BITS-1:0]               tick,
    output mnpt_pkg::pair_ctrl_t               ctrl,
    output logic [TICK_BITS-1:0]               start_q,
    output logic [TICK_BITS-1:0]               tick_q
);
    import mnpt_pkg::*;

    logic [TICK_BITS-1:0]    start_mem [NOTE_COUNT];
    logic [TICK_BITS-1:0]    rd_reg;
    logic [NOTE_COUNT-1:0]   open_reg;
    logic [NOTE_COUNT-1:0]   open_next;
    logic [VEL_BITS-1:0]     last_vel_reg;
    logic [VEL_BITS-1:0]     last_vel_next;
    logic                    hit_reg;
    logic                    hit_next;
    logic [PITCH_BITS-1:0]   pitch_reg;
    logic [VEL_BITS-1:0]     strength_reg;
    logic [TICK_BITS-1:0]    tick_reg;
    logic [STATUS_BITS-1:0]  cmd;
    logic                    is_on;
    logic                    is_off;
    logic                    off_hit;

    assign cmd     = status_byte & CMD_MASK;
    assign is_on   = (cmd == CMD_NOTE_ON);
    assign is_off  = (cmd == CMD_NOTE_OFF);
    assign off_hit = is_off && open_reg[pitch];

    // start ticks: one write port for note-on, one registered read for every other accepted event
    always_ff @(posedge clk)
    begin
        if (accept && is_on)
        begin
            start_mem[pitch] <= tick;
        end
        else if (accept)
        begin
            rd_reg <= start_mem[pitch];
        end
    end

    always_comb
    begin
        open_next     = open_reg;
        last_vel_next = last_vel_reg;
        if (accept && is_on)
        begin
            open_next[pitch] = 1'b1;
            last_vel_next    = velocity;
        end
        else if (accept && off_hit)
        begin
            open_next[pitch] = 1'b0;
        end
    end

    always_comb
    begin
        hit_next = hit_reg;
        if (accept)
        begin
            hit_next = off_hit;
        end
        else if (advance)
        begin
            hit_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg     <= '0;
            last_vel_reg <= '0;
            hit_reg      <= 1'b0;
        end
        else
        begin
            open_reg     <= open_next;
            last_vel_reg <= last_vel_next;
            hit_reg      <= hit_next;
        end
    end

    // a note-off leaves the last velocity as is, so the current value goes along
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pitch_reg    <= pitch;
            strength_reg <= last_vel_reg;
            tick_reg     <= tick;
        end
    end

    assign ctrl.hit      = hit_reg;
    assign ctrl.pitch    = pitch_reg;
    assign ctrl.strength = strength_reg;
    assign start_q       = rd_reg;
    assign tick_q        = tick_reg;

endmodule

/* hdl/mnpt_out.sv */
`timescale 1ns / 1ps

module mnpt_out #(
    parameter int TICK_BITS = mnpt_pkg::TICK_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  mnpt_pkg::pair_ctrl_t               ctrl,
    input  logic [TICK_BITS-1:0]               start_q,
    input  logic [TICK_BITS-1:0]               tick_q,
    input  logic                               out_stall,
    output logic                               advance,
    output logic                               out_valid,
    output logic [mnpt_pkg::PORT_TICK_W-1:0]   start_tick,
    output logic [mnpt_pkg::PITCH_BITS-1:0]    note_pitch,
    output logic [mnpt_pkg::PORT_TICK_W-1:0]   note_length,
    output logic [mnpt_pkg::VEL_BITS-1:0]      note_strength
);
    import mnpt_pkg::*;

    logic                    valid_reg;
    logic                    valid_next;
    logic [TICK_BITS-1:0]    length;
    logic [PORT_TICK_W-1:0]  start_reg;
    logic [PITCH_BITS-1:0]   pitch_reg;
    logic [PORT_TICK_W-1:0]  length_reg;
    logic [VEL_BITS-1:0]     strength_reg;

    assign advance = !valid_reg || !out_stall;
    // wraps modulo the tick width
    assign length  = tick_q - start_q;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = ctrl.hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && ctrl.hit)
        begin
            start_reg    <= PORT_TICK_W'(start_q);
            pitch_reg    <= ctrl.pitch;
            length_reg   <= PORT_TICK_W'(length);
            strength_reg <= ctrl.strength;
        end
    end

    assign out_valid     = valid_reg;
    assign start_tick    = start_reg;
    assign note_pitch    = pitch_reg;
    assign note_length   = length_reg;
    assign note_strength = strength_reg;

endmodule

/* hdl/mnpt_checker.sv */
`timescale 1ns / 1ps

module mnpt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [7:0]  status_byte,
    input logic [6:0]  note_number,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] start_tick,
    input logic [31:0] note_length
);
    import mnpt_pkg::*;

    logic on_acc;
    logic off_acc;

    assign on_acc  = in_valid && !in_stall && ((status_byte & CMD_MASK) == CMD_NOTE_ON);
    assign off_acc = in_valid && !in_stall && ((status_byte & CMD_MASK) == CMD_NOTE_OFF);

    // the input only backs up behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while output free");

    // a new result always comes from an accepted note-off, registered first in the table stage
    a_rise_from_off: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(off_acc, 2))
        else $error("result without a note-off");

    // note-on followed at once by note-off of the same pitch yields a result
    a_pair_result: assert property (@(posedge clk) disable iff (!rst_n)
        (off_acc && $past(on_acc) && $past(rst_n) &&
         (note_number == $past(note_number))) |=> ##1 out_valid)
        else $error("note pair lost");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
        (out_valid && $stable(start_tick) && $stable(note_length)))
        else $error("held result changed");

endmodule

bind midi_note_pair_tracker_unit mnpt_checker u_mnpt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .status_byte (status_byte),
    .note_number (note_number),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .start_tick  (start_tick),
    .note_length (note_length)
);

/* test/midi_note_pair_tracker_unit_tb.sv */
`timescale 1ns / 1ps

module midi_note_pair_tracker_unit_tb;

    import mnpt_pkg::*;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [PITCH_BITS-1:0]  pitch;
        logic [VEL_BITS-1:0]    vel;
        logic [PORT_TICK_W-1:0] tick;
    } note_event_t;

    typedef struct packed {
        logic [PORT_TICK_W-1:0] start;
        logic [PITCH_BITS-1:0]  pitch;
        logic [PORT_TICK_W-1:0] length;
        logic [VEL_BITS-1:0]    strength;
    } finished_note_t;

    typedef struct packed {
        note_event_t    ev;
        logic           typed;
        logic           typed_hit;
        finished_note_t typed_note;
    } event_row_t;

    localparam int ROW_COUNT     = 25;
    localparam int PHASE_EVENTS  = 131;
    localparam int POOL_SIZE     = 8;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [STATUS_BITS-1:0] status_byte = '0;
    logic [PITCH_BITS-1:0]  note_number = '0;
    logic [VEL_BITS-1:0]    note_velocity = '0;
    logic [PORT_TICK_W-1:0] event_tick = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [PORT_TICK_W-1:0] start_tick;
    logic [PITCH_BITS-1:0]  note_pitch;
    logic [PORT_TICK_W-1:0] note_length;
    logic [VEL_BITS-1:0]    note_strength;

    // shadow of the open-note table
    logic [PORT_TICK_W-1:0] open_start_tick [NOTE_COUNT];
    logic                   note_open [NOTE_COUNT];
    logic [VEL_BITS-1:0]    last_strength;

    finished_note_t finished_notes_q [$];
    int             mismatch_count = 0;
    int             sender_idle_pct = 0;
    int             receiver_stall_pct = 0;

    // status, pitch, velocity, tick, typed, result, start, pitch, length, strength
    event_row_t event_rows [ROW_COUNT] = '{
        '{'{8'h80,   7'd5,   7'd0, 32'h0000_0000}, 1'b1, 1'b0, '{32'h0,   7'd0,  32'h0,  7'd0}},
        '{'{8'h9f, 7'd127, 7'd127, 32'h0000_0000}, 1'b1, 1'b0, '{32'h0,   7'd0,  32'h0,  7'd0}},
        '{'{8'h8f, 7'd127,   7'd0, 32'hffff_ffff}, 1'b1, 1'b1,
          '{32'h0, 7'd127, 32'hffff_ffff, 7'd127}},
        '{'{8'h90,   7'd0,   7'd0, 32'hffff_ffff}, 1'b1, 1'b0, '{32'h0,   7'd0,  32'h0,  7'd0}},
        '{'{8'h80,   7'd0, 7'd127, 32'h0000_0004}, 1'b1, 1'b1,
          '{32'hffff_ffff, 7'd0, 32'd5, 7'd0}},
        '{'{8'h80,   7'd0, 7'd127, 32'h0000_0004}, 1'b1, 1'b0, '{32'h0,   7'd0,  32'h0,  7'd0}},
        '{'{8'h93,  7'd60, 7'd100, 32'd100},       1'b1, 1'b0, '{32'h0,   7'd0,  32'h0,  7'd0}},
        '{'{8'h93,  7'd60,  7'd50, 32'd200},       1'b1, 1'b0, '{32'h0,   7'd0,  32'h0,  7'd0}},
        '{'{8'h83,  7'd60,  7'd11, 32'd250},       1'b1, 1'b1, '{32'd200, 7'd60, 32'd50, 7'd50}},
        '{'{8'h90,  7'd61,  7'd33, 32'd300},       1'b1, 1'b0, '{32'h0,   7'd0,  32'h0,  7'd0}},
        '{'{8'ha0,  7'd61,   7'd5, 32'd301},       1'b1, 1'b0, '{32'h0,   7'd0,  32'h0,  7'd0}},
        '{'{8'hb0,  7'd61,   7'd6, 32'd302},       1'b1, 1'b0, '{32'h0,   7'd0,  32'h0,  7'd0}},
        '{'{8'hc0,  7'd61,   7'd7, 32'd303},       1'b1, 1'b0, '{32'h0,   7'd0,  32'h0,  7'd0}},
        '{'{8'hd0,  7'd61,   7'd8, 32'd304},       1'b1, 1'b0, '{32'h0,   7'd0,  32'h0,  7'd0}},
        '{'{8'he0,  7'd61,   7'd9, 32'd305},       1'b1, 1'b0, '{32'h0,   7'd0,  32'h0,  7'd0}},
        '{'{8'hf0,  7'd61,  7'd10, 32'd306},       1'b1, 1'b0, '{32'h0,   7'd0,  32'h0,  7'd0}},
        '{'{8'hff,  7'd61,  7'd11, 32'd307},       1'b1, 1'b0, '{32'h0,   7'd0,  32'h0,  7'd0}},
        '{'{8'h00,  7'd61,  7'd12, 32'd308},       1'b1, 1'b0, '{32'h0,   7'd0,  32'h0,  7'd0}},
        '{'{8'h70,  7'd61,  7'd13, 32'd309},       1'b1, 1'b0, '{32'h0,   7'd0,  32'h0,  7'd0}},
        '{'{8'h8a,  7'd61,  7'd99, 32'd310},       1'b1, 1'b1, '{32'd300, 7'd61, 32'd10, 7'd33}},
        '{'{8'h95,  7'd10,   7'd1, 32'd1000},      1'b0, 1'b0, '{32'h0,   7'd0,  32'h0,  7'd0}},
        '{'{8'h95,  7'd20,   7'd2, 32'd1001},      1'b0, 1'b0, '{32'h0,   7'd0,  32'h0,  7'd0}},
        '{'{8'h85,  7'd10,   7'd0, 32'd1010},      1'b0, 1'b0, '{32'h0,   7'd0,  32'h0,  7'd0}},
        '{'{8'h95,  7'd20,   7'd3, 32'd1020},      1'b0, 1'b0, '{32'h0,   7'd0,  32'h0,  7'd0}},
        '{'{8'h85,  7'd20,   7'd0, 32'd1030},      1'b0, 1'b0, '{32'h0,   7'd0,  32'h0,  7'd0}}
    };

    midi_note_pair_tracker_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .status_byte   (status_byte),
        .note_number   (note_number),
        .note_velocity (note_velocity),
        .event_tick    (event_tick),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .start_tick    (start_tick),
        .note_pitch    (note_pitch),
        .note_length   (note_length),
        .note_strength (note_strength)
    );

    always #5 clk = ~clk;

    function automatic void predict_finished_note(input note_event_t ev, output logic hit,
                                                  output finished_note_t note);
        logic [STATUS_BITS-1:0] cmd;
        cmd  = ev.status & CMD_MASK;
        hit  = 1'b0;
        note = '0;
        if (cmd == CMD_NOTE_ON)
        begin
            open_start_tick[ev.pitch] = ev.tick;
            note_open[ev.pitch]       = 1'b1;
            last_strength             = ev.vel;
        end
        else if (cmd == CMD_NOTE_OFF && note_open[ev.pitch])
        begin
            hit                 = 1'b1;
            note.start          = open_start_tick[ev.pitch];
            note.pitch          = ev.pitch;
            note.length         = ev.tick - open_start_tick[ev.pitch];
            note.strength       = last_strength;
            note_open[ev.pitch] = 1'b0;
        end
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic drive_event(input event_row_t row);
        logic           hit;
        finished_note_t note;
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        status_byte   <= row.ev.status;
        note_number   <= row.ev.pitch;
        note_velocity <= row.ev.vel;
        event_tick    <= row.ev.tick;
        do
            @(posedge clk);
        while (in_stall);
        predict_finished_note(row.ev, hit, note);
        if (row.typed)
        begin
            if (row.typed_hit)
                finished_notes_q = {finished_notes_q, row.typed_note};
        end
        else if (hit)
        begin
            finished_notes_q = {finished_notes_q, note};
        end
        @(negedge clk);
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (finished_notes_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);

    always @(posedge clk)
    begin
        finished_note_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (finished_notes_q.size() == 0)
            begin
                $error("unexpected finished note: pitch %0d start %0h", note_pitch, start_tick);
                mismatch_count++;
            end
            else
            begin
                want = finished_notes_q.pop_front();
                if (start_tick !== want.start)
                begin
                    $error("start_tick: expected %0h, actual %0h", want.start, start_tick);
                    mismatch_count++;
                end
                if (note_pitch !== want.pitch)
                begin
                    $error("note_pitch: expected %0d, actual %0d", want.pitch, note_pitch);
                    mismatch_count++;
                end
                if (note_length !== want.length)
                begin
                    $error("note_length: expected %0h, actual %0h", want.length, note_length);
                    mismatch_count++;
                end
                if (note_strength !== want.strength)
                begin
                    $error("note_strength: expected %0d, actual %0d", want.strength,
                           note_strength);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        event_row_t             row;
        logic [PITCH_BITS-1:0]  pitch_pool [POOL_SIZE];
        logic [PORT_TICK_W-1:0] tick_now;
        int                     events_done;
        int                     roll;

        for (int i = 0; i < NOTE_COUNT; i++)
        begin
            note_open[i]       = 1'b0;
            open_start_tick[i] = '0;
        end
        last_strength = '0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < ROW_COUNT; i++)
            drive_event(event_rows[i]);
        // hold the sender off until all expected finished notes have come out
        wait_for_drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_idle_pct = 0;  receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct = 57; receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;  receiver_stall_pct = 57;
                end
                default:
                begin
                    sender_idle_pct = 12; receiver_stall_pct = 12;
                end
            endcase
            // a few pitches per phase so note-offs mostly find an open note
            for (int i = 0; i < POOL_SIZE; i++)
                pitch_pool[i] = PITCH_BITS'($urandom_range(0, NOTE_COUNT - 1));
            tick_now    = $urandom;
            events_done = 0;
            while (events_done < PHASE_EVENTS)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 5)
                    tick_now += $urandom;
                else if (roll >= 15)
                    tick_now += $urandom_range(1, 2000);
                row        = '0;
                row.ev.tick = tick_now;
                row.ev.vel  = VEL_BITS'($urandom_range(0, 127));
                row.ev.pitch = ($urandom_range(0, 99) < 85)
                               ? pitch_pool[$urandom_range(0, POOL_SIZE - 1)]
                               : PITCH_BITS'($urandom_range(0, NOTE_COUNT - 1));
                roll = $urandom_range(0, 99);
                if (roll < 45)
                    row.ev.status = CMD_NOTE_ON | STATUS_BITS'($urandom_range(0, 15));
                else if (roll < 88)
                    row.ev.status = CMD_NOTE_OFF | STATUS_BITS'($urandom_range(0, 15));
                else
                    row.ev.status = STATUS_BITS'($urandom_range(0, 255));
                drive_event(row);
                events_done++;
            end
            if (phase == 3)
                receiver_stall_pct = 0;
            wait_for_drain();
        end

        if (mismatch_count == 0 && finished_notes_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* files.f */
hdl/mnpt_pkg.sv
hdl/mnpt_table.sv
hdl/mnpt_out.sv
hdl/midi_note_pair_tracker_unit.sv
hdl/mnpt_checker.sv
test/midi_note_pair_tracker_unit_tb.sv
